// ===== design/ghb_pkg.sv =====
`timescale 1ns / 1ps

package ghb_pkg;

  localparam int unsigned COUNT_BITS_DEF = 24;

  localparam int unsigned NUM_BINS  = 256;
  localparam int unsigned BIN_W     = 8;
  localparam int unsigned ROW_W     = 8;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned SCALE_W   = 24;
  localparam int unsigned OUT_CNT_W = 24;
  localparam int unsigned REQ_W     = 2;

  // (256 - row) needs 9 bits, times the 24-bit scale
  localparam int unsigned SPAN_W = ROW_W + 1;
  localparam int unsigned PROD_W = SPAN_W + SCALE_W;

  localparam logic [SCALE_W-1:0]   SCALE_RESET = 24'd55000;
  localparam logic [PIX_W-1:0]     PIX_BLACK   = 8'd0;
  localparam logic [PIX_W-1:0]     PIX_WHITE   = 8'd255;
  localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = 24'hFF_FFFF;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_RENDER = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // controller -> datapath
  typedef struct packed {
    logic acc;       // item taken, launch bin read
    logic clr;       // drop every bin to zero
    logic wr_en;     // write incremented count back
    logic cap_en;    // capture count and scaled threshold
    logic out_load;  // load result into the output register
  } ghb_cmd_t;

  // datapath and ports -> controller
  typedef struct packed {
    logic in_valid;
    req_e req_type;
    logic out_free;
  } ghb_stat_t;

endpackage

// ===== design/ghb_ctrl.sv =====
`timescale 1ns / 1ps

module ghb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ghb_pkg::ghb_stat_t stat_i,
  output ghb_pkg::ghb_cmd_t  cmd_o,
  output logic              in_ready_o
);
  import ghb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_ready_o && stat_i.in_valid;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.acc      = acc;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          unique case (stat_i.req_type)
            REQ_ADD, REQ_RENDER: state_d = ST_READ;
            REQ_CLEAR:           cmd_o.clr = 1'b1;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        // the item's type was latched alongside the read
        if (stat_i.req_type == REQ_RENDER) begin
          cmd_o.cap_en = 1'b1;
          state_d      = ST_CMP;
        end else begin
          cmd_o.wr_en = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_CMP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_read_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q != ST_READ)
    else $error("bin read held longer than one cycle");

  a_cmp_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP && !stat_i.out_free) |=> state_q == ST_CMP)
    else $error("render result dropped while output busy");

  a_render_reads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && stat_i.req_type == REQ_RENDER) |=> state_q == ST_READ)
    else $error("render item did not start a bin read");
`endif

endmodule

// ===== design/ghb_dp.sv =====
`timescale 1ns / 1ps

module ghb_dp #(
  parameter int unsigned COUNT_BITS = ghb_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ghb_pkg::ghb_cmd_t               cmd_i,
  input  logic [ghb_pkg::REQ_W-1:0]       req_type_i,
  input  logic [ghb_pkg::BIN_W-1:0]       pixel_value_i,
  input  logic [ghb_pkg::BIN_W-1:0]       chart_column_i,
  input  logic [ghb_pkg::ROW_W-1:0]       chart_row_i,
  input  logic                            cfg_we_i,
  input  logic [ghb_pkg::SCALE_W-1:0]     cfg_data_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [ghb_pkg::PIX_W-1:0]       bar_pixel_o,
  output logic [ghb_pkg::OUT_CNT_W-1:0]   bin_count_o,
  output logic                            out_free_o,
  output ghb_pkg::req_e                   req_type_o
);
  import ghb_pkg::*;

  localparam int unsigned LHS_W = COUNT_BITS + 8;
  localparam int unsigned CMP_W = (LHS_W > PROD_W) ? LHS_W : PROD_W;
  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]   vld_q;

  logic [BIN_W-1:0]      addr_q;
  logic [ROW_W-1:0]      row_q;
  req_e                  req_q;
  logic [COUNT_BITS-1:0] rd_q;
  logic                  rd_vld_q;
  logic [SCALE_W-1:0]    scale_q;

  logic [COUNT_BITS-1:0] cnt_q;
  logic [PROD_W-1:0]     prod_q;

  logic                  out_valid_q;
  logic [PIX_W-1:0]      pix_q;
  logic [OUT_CNT_W-1:0]  ocnt_q;

  logic [BIN_W-1:0]      rd_addr;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [SPAN_W-1:0]     span;
  logic [CMP_W-1:0]      lhs;
  logic [CMP_W-1:0]      rhs;
  logic [CMP_W-1:0]      cnt_ext;

  assign rd_addr = (req_e'(req_type_i) == REQ_ADD) ? pixel_value_i : chart_column_i;
  assign cnt     = rd_vld_q ? rd_q : '0;
  assign cnt_inc = (cnt == CntMax) ? cnt : cnt + COUNT_BITS'(1);
  assign span    = SPAN_W'(NUM_BINS) - SPAN_W'(row_q);

  assign cnt_ext = CMP_W'(cnt_q);
  assign lhs     = cnt_ext << 8;
  assign rhs     = CMP_W'(prod_q);

  // bin store, read data registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      rd_q   <= mem[rd_addr];
      addr_q <= rd_addr;
      row_q  <= chart_row_i;
      req_q  <= req_e'(req_type_i);
    end
    if (cmd_i.wr_en) begin
      mem[addr_q] <= cnt_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      cnt_q  <= cnt;
      prod_q <= span * scale_q;
    end
    if (cmd_i.out_load) begin
      pix_q  <= (lhs > rhs) ? PIX_BLACK : PIX_WHITE;
      ocnt_q <= (cnt_ext > CMP_W'(OUT_CNT_MAX)) ? OUT_CNT_MAX : cnt_ext[OUT_CNT_W-1:0];
    end
  end

  // a bin without its valid bit reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      scale_q     <= SCALE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (cmd_i.clr) begin
        vld_q <= '0;
      end else if (cmd_i.wr_en) begin
        vld_q[addr_q] <= 1'b1;
      end
      if (cfg_we_i) begin
        scale_q <= cfg_data_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_free_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign bar_pixel_o = pix_q;
  assign bin_count_o = ocnt_q;
  assign req_type_o  = req_q;

endmodule

// ===== design/gray_histogram_bar_chart.sv =====
`timescale 1ns / 1ps

// gray histogram bar chart: counts 8-bit grayscale pixels into 256 bins and
// renders the histogram as a 256x256 bar chart, one chart pixel per render
// item. s_tuser carries the request kind (0 add pixel, 1 render, 2 clear all
// bins, 3 ignored). a chart pixel at column c, row r (row 0 on top) is black
// (0) when count[c]*256 > (256-r)*bar_scale, white (255) otherwise; its item
// also returns the bin count, capped at 2^24-1. counts saturate at
// 2^COUNT_BITS-1. the bins sit in a single-port memory with one valid bit per
// bin, so a clear needs no sweep, and reset needs no
// clearing pass. items are handled one at a time: clear and ignored kinds
// finish as they are taken, an add reads the bin, then writes it back, and a
// render reads the bin, does the 9x24 threshold multiply, then compares into
// the output register, waiting while that register stays full. bar_scale may be
// written through the cfg port whenever no item is in flight; reset value 55000.

module gray_histogram_bar_chart #(
  parameter int unsigned COUNT_BITS = ghb_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // pixel_value[7:0], chart_column[15:8], chart_row[23:16]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // bar_pixel[7:0], bin_count[31:8]
  // bar_scale register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i
);
  import ghb_pkg::*;

  ghb_cmd_t  cmd;
  ghb_stat_t stat;
  req_e      req_lat;
  logic      out_free;
  logic      in_ready;
  logic [PIX_W-1:0]     bar_pixel;
  logic [OUT_CNT_W-1:0] bin_count;

  // type of the new item while idle, of the latched item otherwise
  assign stat.in_valid = s_tvalid;
  assign stat.req_type = in_ready ? req_e'(s_tuser) : req_lat;
  assign stat.out_free = out_free;

  assign s_tready    = in_ready;
  assign cfg_ready_o = 1'b1;
  assign m_tdata     = {bin_count, bar_pixel};

  ghb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  ghb_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (s_tuser),
    .pixel_value_i  (s_tdata[7:0]),
    .chart_column_i (s_tdata[15:8]),
    .chart_row_i    (s_tdata[23:16]),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (m_tready),
    .out_valid_o    (m_tvalid),
    .bar_pixel_o    (bar_pixel),
    .bin_count_o    (bin_count),
    .out_free_o     (out_free),
    .req_type_o     (req_lat)
  );

endmodule
